@@ src/priority_dispatch_queue_assert.svh @@
// Assertion macros for the priority dispatch queue.
`ifndef PRIORITY_DISPATCH_QUEUE_ASSERT_SVH
`define PRIORITY_DISPATCH_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define PDQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("priority dispatch queue check failed");
// Next-cycle implication, checked on every rising clock edge outside reset.
`define PDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("priority dispatch queue check failed");
`else
`define PDQ_ASSERT_NOW(label, ante, cons)
`define PDQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ src/pdq_pkg.sv @@
// Shared types and codes for the priority dispatch queue.
package pdq_pkg;

  // Command codes carried by an input transaction.
  typedef enum logic [1:0] {
    CMD_ENQ      = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_PUSH     = 2'd2,
    CMD_POP      = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_QFULL  = 3'd1,
    ST_QEMPTY = 3'd2,
    ST_SFULL  = 3'd3,
    ST_SEMPTY = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_DSP,
    S_POP,
    S_DONE
  } state_t;

  // One waiting queue entry.
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] name;
    logic [7:0]  prio;
  } qent_t;

  // One block stack entry.
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] name;
  } sent_t;

endpackage

@@ src/priority_dispatch_queue.sv @@
// Priority dispatch queue: sorted entry queue walked by one compare unit, plus a block stack.
// Enqueue walks from the tail towards the head, moving lower-priority entries up, then fills the gap.
// Dispatch walks the whole queue; push writes the stack on acceptance; pop reads the top back.
// The whole walk runs through one queue RAM port pair, one entry per cycle.
// A new transaction is taken only in the idle state; a finished result may wait at the output.
// Synchronous active-high reset empties the queue and the stack; RAM contents are not cleared.
module priority_dispatch_queue #(
  parameter int QUEUE_DEPTH = 128,
  parameter int STACK_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] proc_id,
  input  logic [15:0] name_handle,
  input  logic [7:0]  priority_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  slot,
  output logic [15:0] out_id,
  output logic [15:0] out_name,
  output logic        stacked,
  output logic [7:0]  queue_count,
  output logic [7:0]  stack_count
);

  import pdq_pkg::*;

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);

  state_t         state, state_next;
  logic [QAW-1:0] walk_idx, walk_idx_next;
  logic [QCW-1:0] qsize, qsize_next;
  logic [SCW-1:0] stop, stop_next;
  logic [15:0]    op_id, op_id_next;
  logic [15:0]    op_name, op_name_next;
  logic [7:0]     op_prio, op_prio_next;
  status_t        res_status, res_status_next;
  logic [QCW-1:0] res_slot, res_slot_next;
  logic [15:0]    res_id, res_id_next;
  logic [15:0]    res_name, res_name_next;
  logic           res_stacked, res_stacked_next;
  logic           out_load;

  logic           q_we;
  logic [QAW-1:0] q_waddr, q_raddr;
  qent_t          q_wdata, q_rdata;
  logic           s_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  sent_t          s_wdata, s_rdata;

  // Queue entry storage, kept sorted with the head at address zero.
  pdq_ram #(
    .WIDTH ($bits(qent_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // Block stack storage, growing upwards from address zero.
  pdq_ram #(
    .WIDTH ($bits(sent_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign in_stall = (state != S_IDLE);

  // Sequencer: next state, working registers and RAM port control.
  always_comb begin
    state_next       = state;
    walk_idx_next    = walk_idx;
    qsize_next       = qsize;
    stop_next        = stop;
    op_id_next       = op_id;
    op_name_next     = op_name;
    op_prio_next     = op_prio;
    res_status_next  = res_status;
    res_slot_next    = res_slot;
    res_id_next      = res_id;
    res_name_next    = res_name;
    res_stacked_next = res_stacked;
    out_load         = 1'b0;
    q_we             = 1'b0;
    q_waddr          = walk_idx;
    q_wdata          = q_rdata;
    q_raddr          = walk_idx;
    s_we             = 1'b0;
    s_waddr          = stop[SAW-1:0];
    s_wdata          = '{id: op_id, name: op_name};
    s_raddr          = SAW'(stop - SCW'(1));

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_id_next       = proc_id;
          op_name_next     = name_handle;
          op_prio_next     = priority_req;
          res_status_next  = ST_OK;
          res_slot_next    = '0;
          res_id_next      = '0;
          res_name_next    = '0;
          res_stacked_next = 1'b0;
          state_next       = S_DONE;
          unique case (cmd_t'(cmd))
            CMD_ENQ: begin
              if (qsize == QCW'(QUEUE_DEPTH)) begin
                res_status_next = ST_QFULL;
              end else if (qsize == '0) begin
                walk_idx_next = '0;
                state_next    = S_INS_PUT;
              end else begin
                // Start the walk from the tail of the queue.
                walk_idx_next = qsize[QAW-1:0];
                q_raddr       = QAW'(qsize - QCW'(1));
                state_next    = S_INS_CMP;
              end
            end
            CMD_DISPATCH: begin
              if (qsize == '0) begin
                res_status_next = ST_QEMPTY;
              end else begin
                walk_idx_next = '0;
                q_raddr       = '0;
                state_next    = S_DSP;
              end
            end
            CMD_PUSH: begin
              if (stop == SCW'(STACK_DEPTH)) begin
                res_status_next = ST_SFULL;
              end else begin
                s_we      = 1'b1;
                s_wdata   = '{id: proc_id, name: name_handle};
                stop_next = stop + SCW'(1);
              end
            end
            CMD_POP: begin
              if (stop == '0) begin
                res_status_next = ST_SEMPTY;
              end else begin
                stop_next  = stop - SCW'(1);
                state_next = S_POP;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_INS_CMP: begin
        // The entry below the gap has lower priority: move it up one place.
        if (q_rdata.prio < op_prio) begin
          q_we          = 1'b1;
          q_waddr       = walk_idx;
          q_wdata       = q_rdata;
          walk_idx_next = walk_idx - QAW'(1);
          q_raddr       = walk_idx - QAW'(2);
          if (walk_idx == QAW'(1)) begin
            state_next = S_INS_PUT;
          end
        end else begin
          q_we          = 1'b1;
          q_waddr       = walk_idx;
          q_wdata       = '{id: op_id, name: op_name, prio: op_prio};
          res_slot_next = QCW'(walk_idx) + QCW'(1);
          qsize_next    = qsize + QCW'(1);
          state_next    = S_DONE;
        end
      end

      S_INS_PUT: begin
        q_we          = 1'b1;
        q_waddr       = walk_idx;
        q_wdata       = '{id: op_id, name: op_name, prio: op_prio};
        res_slot_next = QCW'(walk_idx) + QCW'(1);
        qsize_next    = qsize + QCW'(1);
        state_next    = S_DONE;
      end

      S_DSP: begin
        // The head is returned, and stacked if the stack has room; every later entry moves down one place.
        if (walk_idx == '0) begin
          res_id_next   = q_rdata.id;
          res_name_next = q_rdata.name;
          if (stop != SCW'(STACK_DEPTH)) begin
            s_we             = 1'b1;
            s_wdata          = '{id: q_rdata.id, name: q_rdata.name};
            stop_next        = stop + SCW'(1);
            res_stacked_next = 1'b1;
          end
        end else begin
          q_we    = 1'b1;
          q_waddr = walk_idx - QAW'(1);
          q_wdata = q_rdata;
        end
        if ((QCW'(walk_idx) + QCW'(1)) < qsize) begin
          q_raddr       = walk_idx + QAW'(1);
          walk_idx_next = walk_idx + QAW'(1);
        end else begin
          qsize_next = qsize - QCW'(1);
          state_next = S_DONE;
        end
      end

      S_POP: begin
        res_id_next = s_rdata.id;
        state_next  = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      qsize     <= '0;
      stop      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      qsize <= qsize_next;
      stop  <= stop_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    walk_idx    <= walk_idx_next;
    op_id       <= op_id_next;
    op_name     <= op_name_next;
    op_prio     <= op_prio_next;
    res_status  <= res_status_next;
    res_slot    <= res_slot_next;
    res_id      <= res_id_next;
    res_name    <= res_name_next;
    res_stacked <= res_stacked_next;
  end

  // Output register; it only loads when empty or when its transaction is taken.
  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= res_status;
      slot        <= 8'(res_slot);
      out_id      <= res_id;
      out_name    <= res_name;
      stacked     <= res_stacked;
      queue_count <= 8'(qsize);
      stack_count <= 8'(stop);
    end
  end

  `include "priority_dispatch_queue_assert.svh"

  // The fill counts never pass their depths.
  `PDQ_ASSERT_NOW(a_qsize_bound, 1'b1, qsize <= QCW'(QUEUE_DEPTH))
  `PDQ_ASSERT_NOW(a_stop_bound, 1'b1, stop <= SCW'(STACK_DEPTH))
  // An insertion walk only runs on a queue that is neither empty nor full.
  `PDQ_ASSERT_NOW(a_walk_room, state == S_INS_CMP,
                  qsize != '0 && qsize < QCW'(QUEUE_DEPTH))
  // A loaded result is presented in the following cycle.
  `PDQ_ASSERT_NEXT(a_load_shows, out_load, out_valid && state == S_IDLE)

endmodule

@@ src/pdq_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
module pdq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data appears in the cycle after the address.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
